/* design/pfa_pkg.sv */
// Package for the page frame allocator with wait queue.
// Holds field widths, operation and result codes, the result record and the FSM states.
// No dependencies.
package pfa_pkg;

  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int SIZE_W = 20;
  localparam int PS_W   = 13;
  localparam int FIU_W  = 9;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 9;
  localparam int QLEN_W = 5;
  localparam int CIDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVE   = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_ADMIT    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_QUEUED   = 3'd0,
    K_DROPPED  = 3'd1,
    K_RELEASED = 3'd2,
    K_ADMITTED = 3'd3,
    K_NONE     = 3'd4
  } kind_t;

  localparam logic [CIDX_W-1:0] CFG_PAGE_SIZE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAMES    = 2'd1;

  localparam logic [PS_W-1:0]  PAGE_SIZE_RST = 13'd100;
  localparam logic [FIU_W-1:0] FRAMES_RST    = 9'd256;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   free;
    logic [QLEN_W-1:0]  qlen;
  } res_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CNT,
    S_REL,
    S_ARR,
    S_QRD,
    S_QCHK,
    S_DIV,
    S_SHIFT,
    S_ALC,
    S_PUSH,
    S_FIN
  } state_t;

endpackage

/* design/pfa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pfa_div.sv */
// Restoring divider, one quotient bit per cycle, for the page count of an admission.
// Depends on pfa_pkg.
module pfa_div
  import pfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] num,
  input  logic [PS_W-1:0]   den,
  output logic              done,
  output logic [SIZE_W-1:0] quo,
  output logic              rem_nz
);

  localparam int CW = $clog2(SIZE_W + 1);

  logic [PS_W:0]   rem_r, rem_nxt;
  logic [SIZE_W-1:0] quo_r, quo_nxt;
  logic [PS_W-1:0] den_r, den_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic [PS_W:0]   sh;
  logic [PS_W+1:0] dif;
  logic            ge;

  always_comb begin
    sh       = {rem_r[PS_W-1:0], quo_r[SIZE_W-1]};
    dif      = {1'b0, sh} - {2'b00, den_r};
    ge       = !dif[PS_W+1];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
      cnt_nxt = CW'(SIZE_W);
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? dif[PS_W:0] : sh;
      quo_nxt = {quo_r[SIZE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done   = done_r;
  assign quo    = quo_r;
  assign rem_nz = (rem_r != '0);

endmodule

/* design/page_frame_allocator_wait_queue.sv */
// Page frame allocator with an ordered wait queue; owner map and queue live in RAMs.
// Arrive counts free frames over the N managed frames, then queues; complete sweeps all FRAMES
// owner entries. An admit pass counts, then scans the queue and skips entries that do not fit;
// each admission divides, shifts the queue, allocates frames and pushes its result. A stalled
// output adds its stall. One item is worked at a time. Synchronous active-low reset empties
// the queue, then the owner map is cleared with the input stalled. Results wait in an output register.
module page_frame_allocator_wait_queue
  import pfa_pkg::*;
#(
  parameter int FRAMES      = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ID_W-1:0]   in_process_id,
  input  logic [SIZE_W-1:0] in_request_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_result_id,
  output logic [CNT_W-1:0]  out_frame_count,
  output logic [CNT_W-1:0]  out_free_frames,
  output logic [QLEN_W-1:0] out_queue_length,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [PS_W-1:0]   cfg_data
);

  localparam int FAW  = $clog2(FRAMES);
  localparam int FCW  = $clog2(FRAMES + 1);
  localparam int QAW  = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int NW   = (FCW > FIU_W) ? FCW : FIU_W;
  localparam int AVW  = FCW + PS_W;
  localparam int MW   = (AVW > SIZE_W) ? AVW : SIZE_W;
  localparam int QEW  = ID_W + SIZE_W;
  localparam int PGW  = SIZE_W + 1;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [ID_W-1:0]   adm_id_r, adm_id_nxt;
  logic [PGW-1:0]    pages_r, pages_nxt;
  logic [FCW-1:0]    sw_cnt_r, sw_cnt_nxt;
  logic              sw_v_r, sw_v_nxt;
  logic [FAW-1:0]    sw_a_r, sw_a_nxt;
  logic [FCW-1:0]    free_r, free_nxt;
  logic [FCW-1:0]    freed_r, freed_nxt;
  logic [FCW-1:0]    got_r, got_nxt;
  logic [QCW-1:0]    qcnt_r, qcnt_nxt;
  logic [QCW-1:0]    q_r, q_nxt;
  logic [QCW-1:0]    qj_r, qj_nxt;
  logic              qv_r, qv_nxt;
  logic [QAW-1:0]    qa_r, qa_nxt;
  res_t              pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PS_W-1:0]   ps_r;
  logic [FIU_W-1:0]  fiu_r;

  logic [PS_W-1:0]   ps_eff;
  logic [NW-1:0]     nf_wide;
  logic [FCW-1:0]    nf;
  logic [FCW-1:0]    sw_lim;
  logic              sw_issue;
  logic              sw_done;
  logic              in_nf;
  logic              match;
  logic              slot_free;
  logic [AVW-1:0]    avail;
  logic              q_issue;

  logic              own_we;
  logic [FAW-1:0]    own_waddr;
  logic [ID_W-1:0]   own_wdata;
  logic [FAW-1:0]    own_raddr;
  logic [ID_W-1:0]   own_rdata;
  logic              q_we;
  logic [QAW-1:0]    q_waddr;
  logic [QEW-1:0]    q_wdata;
  logic [QAW-1:0]    q_raddr;
  logic [QEW-1:0]    q_rdata;

  logic              div_start;
  logic              div_done;
  logic [SIZE_W-1:0] div_quo;
  logic              div_rem_nz;

  pfa_ram #(.WIDTH(ID_W), .DEPTH(FRAMES)) u_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  pfa_ram #(.WIDTH(QEW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  pfa_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (q_rdata[SIZE_W-1:0]),
    .den    (ps_eff),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rem_nz)
  );

  assign ps_eff    = (ps_r == '0) ? PS_W'(1) : ps_r;
  assign nf_wide   = (NW'(fiu_r) > NW'(FRAMES)) ? NW'(FRAMES) : NW'(fiu_r);
  assign nf        = nf_wide[FCW-1:0];
  assign sw_lim    = (state_r == S_REL) ? FCW'(FRAMES) : nf;
  assign sw_issue  = (sw_cnt_r < sw_lim);
  assign sw_done   = !sw_issue && !sw_v_r;
  assign in_nf     = (FCW'(sw_a_r) < nf);
  assign match     = (pid_r != '0) && (own_rdata == pid_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign avail     = AVW'(free_r) * AVW'(ps_eff);
  assign q_issue   = (qj_r < qcnt_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pid_nxt       = pid_r;
    need_nxt      = need_r;
    adm_id_nxt    = adm_id_r;
    pages_nxt     = pages_r;
    sw_cnt_nxt    = sw_cnt_r;
    sw_v_nxt      = 1'b0;
    sw_a_nxt      = sw_cnt_r[FAW-1:0];
    free_nxt      = free_r;
    freed_nxt     = freed_r;
    got_nxt       = got_r;
    qcnt_nxt      = qcnt_r;
    q_nxt         = q_r;
    qj_nxt        = qj_r;
    qv_nxt        = 1'b0;
    qa_nxt        = qj_r[QAW-1:0];
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    own_we        = 1'b0;
    own_waddr     = sw_a_r;
    own_wdata     = '0;
    own_raddr     = sw_cnt_r[FAW-1:0];
    q_we          = 1'b0;
    q_waddr       = qa_r - 1'b1;
    q_wdata       = q_rdata;
    q_raddr       = q_r[QAW-1:0];
    div_start     = 1'b0;
    in_stall      = (state_r != S_IDLE);

    unique case (state_r)
      S_CLR: begin
        own_we     = 1'b1;
        own_waddr  = sw_cnt_r[FAW-1:0];
        sw_cnt_nxt = sw_cnt_r + 1'b1;
        if (sw_cnt_r == FCW'(FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_op);
          pid_nxt    = in_process_id;
          need_nxt   = in_request_size;
          sw_cnt_nxt = '0;
          free_nxt   = '0;
          freed_nxt  = '0;
          pend_v_nxt = 1'b0;
          unique case (op_t'(in_op))
            OP_ARRIVE, OP_ADMIT: state_nxt = S_CNT;
            OP_COMPLETE:         state_nxt = S_REL;
            OP_NOP:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_CNT, S_REL, S_ALC: begin
        sw_v_nxt = sw_issue;
        if (sw_issue) begin
          sw_cnt_nxt = sw_cnt_r + 1'b1;
        end
        if (sw_v_r) begin
          if (state_r == S_CNT) begin
            if (in_nf && own_rdata == '0) begin
              free_nxt = free_r + 1'b1;
            end
          end else if (state_r == S_REL) begin
            if (match) begin
              own_we    = 1'b1;
              freed_nxt = freed_r + 1'b1;
            end
            if (in_nf && (own_rdata == '0 || match)) begin
              free_nxt = free_r + 1'b1;
            end
          end else if (own_rdata == '0 && PGW'(got_r) < pages_r) begin
            own_we    = 1'b1;
            own_wdata = adm_id_r;
            got_nxt   = got_r + 1'b1;
          end
        end
        if (sw_done) begin
          if (state_r == S_CNT) begin
            q_nxt     = '0;
            state_nxt = (op_r == OP_ARRIVE) ? S_ARR : S_QRD;
          end else if (state_r == S_REL) begin
            pend_nxt   = '{K_RELEASED, pid_r, CNT_W'(freed_r), CNT_W'(free_r),
                           QLEN_W'(qcnt_r)};
            pend_v_nxt = 1'b1;
            state_nxt  = S_FIN;
          end else begin
            free_nxt  = free_r - got_r;
            qcnt_nxt  = qcnt_r - 1'b1;
            state_nxt = S_PUSH;
          end
        end
      end
      S_ARR: begin
        if (pid_r == '0 || qcnt_r == QCW'(QUEUE_DEPTH)) begin
          pend_nxt = '{K_DROPPED, pid_r, '0, CNT_W'(free_r), QLEN_W'(qcnt_r)};
        end else begin
          q_we     = 1'b1;
          q_waddr  = qcnt_r[QAW-1:0];
          q_wdata  = {pid_r, need_r};
          qcnt_nxt = qcnt_r + 1'b1;
          pend_nxt = '{K_QUEUED, pid_r, '0, CNT_W'(free_r), QLEN_W'(qcnt_r + 1'b1)};
        end
        pend_v_nxt = 1'b1;
        state_nxt  = S_FIN;
      end
      S_QRD: begin
        if (q_r < qcnt_r) begin
          state_nxt = S_QCHK;
        end else begin
          if (!pend_v_r) begin
            pend_nxt   = '{K_NONE, '0, '0, CNT_W'(free_r), QLEN_W'(qcnt_r)};
            pend_v_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_QCHK: begin
        if (MW'(q_rdata[SIZE_W-1:0]) <= MW'(avail)) begin
          need_nxt   = q_rdata[SIZE_W-1:0];
          adm_id_nxt = q_rdata[QEW-1:SIZE_W];
          div_start  = 1'b1;
          state_nxt  = S_DIV;
        end else begin
          q_nxt     = q_r + 1'b1;
          state_nxt = S_QRD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          pages_nxt = PGW'(div_quo) + PGW'(div_rem_nz);
          qj_nxt    = q_r + 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        q_raddr = qj_r[QAW-1:0];
        qv_nxt  = q_issue;
        if (q_issue) begin
          qj_nxt = qj_r + 1'b1;
        end
        if (qv_r) begin
          q_we = 1'b1;
        end
        if (!q_issue && !qv_r) begin
          sw_cnt_nxt = '0;
          got_nxt    = '0;
          state_nxt  = S_ALC;
        end
      end
      S_PUSH: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_last_nxt  = 1'b0;
            out_valid_nxt = 1'b1;
          end
          pend_nxt   = '{K_ADMITTED, adm_id_r, CNT_W'(got_r), CNT_W'(free_r),
                         QLEN_W'(qcnt_r)};
          pend_v_nxt = 1'b1;
          state_nxt  = S_QRD;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_nxt       = pend_r;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sw_cnt_r    <= '0;
      qcnt_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sw_v_r      <= 1'b0;
      qv_r        <= 1'b0;
      ps_r        <= PAGE_SIZE_RST;
      fiu_r       <= FRAMES_RST;
    end else begin
      state_r     <= state_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      qcnt_r      <= qcnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      sw_v_r      <= sw_v_nxt;
      qv_r        <= qv_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PAGE_SIZE) begin
          ps_r <= cfg_data;
        end else if (cfg_index == CFG_FRAMES) begin
          fiu_r <= cfg_data[FIU_W-1:0];
        end
      end
    end
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    need_r     <= need_nxt;
    adm_id_r   <= adm_id_nxt;
    pages_r    <= pages_nxt;
    sw_a_r     <= sw_a_nxt;
    free_r     <= free_nxt;
    freed_r    <= freed_nxt;
    got_r      <= got_nxt;
    q_r        <= q_nxt;
    qj_r       <= qj_nxt;
    qa_r       <= qa_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_result_id    = out_r.id;
  assign out_frame_count  = out_r.cnt;
  assign out_free_frames  = out_r.free;
  assign out_queue_length = out_r.qlen;
  assign out_last         = out_last_r;

endmodule
